// ----- rtl/core/wemc_pkg.sv -----
// wemc_pkg: shared sizes, link types and control structs for the
// weighted_equalize_min_cost cell chain. No dependencies.
package wemc_pkg;

	// store depth, one cell per tower
	localparam int MAX_TOWERS = 64;

	localparam int H_W    = 16;
	localparam int C_W    = 16;
	localparam int PROD_W = H_W + C_W;
	// a sum of MAX_TOWERS products never exceeds this width
	localparam int ACC_W  = PROD_W + $clog2(MAX_TOWERS);
	localparam int COST_W = 40;
	localparam int WIDE_W = (ACC_W > COST_W) ? ACC_W : COST_W;
	// holds 0..MAX_TOWERS
	localparam int CNT_W  = $clog2(MAX_TOWERS + 1);

	// one tower as it moves along the chain
	typedef struct packed {
		logic           v;
		logic [H_W-1:0] h;
		logic [C_W-1:0] c;
	} tower_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic load;
		logic rotate;
		logic acc_clr;
		logic drain;
	} cell_ctl_t;

	// commands for the minimum scanner
	typedef struct packed {
		logic init;
		logic scan;
	} min_ctl_t;

endpackage

// ----- rtl/core/wemc_cell.sv -----
// wemc_cell: one chain cell. Holds a stored tower, a circulating tower and the
// running cost of equalizing to its own height. Depends on wemc_pkg.
module wemc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wemc_pkg::cell_ctl_t        ctl,
	input  wemc_pkg::tower_t           prev_own,
	input  wemc_pkg::tower_t           prev_strm,
	input  logic [wemc_pkg::ACC_W-1:0] prev_acc,
	output wemc_pkg::tower_t           own,
	output wemc_pkg::tower_t           strm,
	output logic [wemc_pkg::ACC_W-1:0] acc
);
	import wemc_pkg::*;

	logic [H_W-1:0]    own_h_q;
	logic [C_W-1:0]    own_c_q;
	logic              own_v_q;
	logic [H_W-1:0]    sh_q;
	logic [C_W-1:0]    sc_q;
	logic              sv_q;
	logic [PROD_W-1:0] prod_s1;
	logic              pv_s1;
	logic [ACC_W-1:0]  acc_q;
	logic [H_W-1:0]    diff;

	// distance between the circulating tower and our own height
	assign diff = (own_h_q >= sh_q) ? (own_h_q - sh_q) : (sh_q - own_h_q);

	// payload: stored tower, circulating tower, product and running sum
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			own_h_q <= prev_own.h;
			own_c_q <= prev_own.c;
			sh_q    <= prev_own.h;
			sc_q    <= prev_own.c;
		end else if (ctl.rotate) begin
			sh_q <= prev_strm.h;
			sc_q <= prev_strm.c;
		end else if (ctl.drain) begin
			own_h_q <= prev_own.h;
			own_c_q <= prev_own.c;
		end
		prod_s1 <= PROD_W'(diff) * PROD_W'(sc_q);
		if (ctl.acc_clr) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end else if (ctl.drain) begin
			acc_q <= prev_acc;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_v_q <= 1'b0;
			sv_q    <= 1'b0;
			pv_s1   <= 1'b0;
		end else begin
			if (ctl.load || ctl.drain) begin
				own_v_q <= prev_own.v;
			end
			if (ctl.load) begin
				sv_q <= prev_own.v;
			end else if (ctl.rotate) begin
				sv_q <= prev_strm.v;
			end
			pv_s1 <= ctl.rotate && sv_q && own_v_q;
		end
	end

	assign own  = '{v: own_v_q, h: own_h_q, c: own_c_q};
	assign strm = '{v: sv_q, h: sh_q, c: sc_q};
	assign acc  = acc_q;

endmodule

// ----- rtl/core/wemc_min.sv -----
// wemc_min: scans the costs leaving the chain tail, keeps the least one and
// saturates it to the result width. Depends on wemc_pkg.
module wemc_min (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wemc_pkg::min_ctl_t          ctl,
	input  logic                        tail_v,
	input  logic [wemc_pkg::ACC_W-1:0]  tail_acc,
	output logic [wemc_pkg::COST_W-1:0] best
);
	import wemc_pkg::*;

	localparam logic [WIDE_W-1:0] COST_MAX = WIDE_W'({COST_W{1'b1}});

	logic [ACC_W-1:0]  min_q;
	logic              have_q;
	logic [WIDE_W-1:0] wide_min;

	// running minimum over valid cells
	always_ff @(posedge clk) begin
		if (ctl.scan && tail_v && (!have_q || tail_acc < min_q)) begin
			min_q <= tail_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.init) begin
			have_q <= 1'b0;
		end else if (ctl.scan && tail_v) begin
			have_q <= 1'b1;
		end
	end

	// clamp to the result range
	assign wide_min = WIDE_W'(min_q);
	assign best     = (wide_min > COST_MAX) ? COST_W'(COST_MAX) : COST_W'(wide_min);

endmodule

// ----- rtl/core/weighted_equalize_min_cost.sv -----
// weighted_equalize_min_cost: top level; sequencer plus a chain of
// wemc_cell instances feeding wemc_min. Depends on wemc_pkg, wemc_cell, wemc_min.
//
// Channel   Direction  Handshake                 Payload
// tower     in         start & !busy             height, unit_cost, last
// result    out        done (one-cycle strobe)   min_cost, overflow
//
// Towers without last may arrive every cycle.
// After a last beat busy stays high while the sequencer rotates every tower
// past every cell (one multiplier per cell), flushes the pipeline, shifts the
// costs out to the minimum scanner and registers the result in ST_RESULT.
// done pulses in the cycle after ST_RESULT.
// Reset clears the sequencer, counts and valid bits; the receiver cannot stall.
module weighted_equalize_min_cost (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [wemc_pkg::H_W-1:0]    height,
	input  logic [wemc_pkg::C_W-1:0]    unit_cost,
	input  logic                        last,
	output logic                        done,
	output logic [wemc_pkg::COST_W-1:0] min_cost,
	output logic                        overflow
);
	import wemc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROTATE,
		ST_FLUSH,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   step_q;
	logic               dropped_q;
	logic               done_q;
	logic [COST_W-1:0]  min_cost_q;
	logic               overflow_q;

	logic               accept;
	logic               full;
	logic               step_end;
	cell_ctl_t          cctl;
	min_ctl_t           mctl;
	tower_t             head;
	tower_t             own_lnk  [MAX_TOWERS];
	tower_t             strm_lnk [MAX_TOWERS];
	logic [ACC_W-1:0]   acc_lnk  [MAX_TOWERS];
	logic [COST_W-1:0]  best;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign full     = (count_q == CNT_W'(MAX_TOWERS));
	assign step_end = (step_q == CNT_W'(MAX_TOWERS - 1));

	// commands to the chain and the minimum scanner
	always_comb begin
		cctl.load    = accept && !full;
		cctl.rotate  = (state_q == ST_ROTATE);
		cctl.acc_clr = (state_q == ST_ROTATE) && (step_q == '0);
		cctl.drain   = (state_q == ST_DRAIN);
		mctl.init    = cctl.acc_clr;
		mctl.scan    = (state_q == ST_DRAIN);
	end

	// new tower enters at the head; invalid towers enter while draining
	assign head = '{v: (state_q == ST_IDLE), h: height, c: unit_cost};

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			step_q     <= '0;
			dropped_q  <= 1'b0;
			done_q     <= 1'b0;
			min_cost_q <= '0;
			overflow_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_RESULT);
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + 1'b1;
						end
						if (last) begin
							step_q  <= '0;
							state_q <= ST_ROTATE;
						end
					end
				end
				ST_ROTATE: begin
					if (step_end) begin
						step_q  <= '0;
						state_q <= ST_FLUSH;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (step_end) begin
						step_q  <= '0;
						state_q <= ST_RESULT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_RESULT: begin
					min_cost_q <= best;
					overflow_q <= dropped_q;
					count_q    <= '0;
					dropped_q  <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// the cell chain; the circulating towers wrap from tail to head
	for (genvar i = 0; i < MAX_TOWERS; i++) begin : g_cell
		wemc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cctl),
			.prev_own  ((i == 0) ? head : own_lnk[(i == 0) ? 0 : i - 1]),
			.prev_strm (strm_lnk[(i == 0) ? MAX_TOWERS - 1 : i - 1]),
			.prev_acc  ((i == 0) ? ACC_W'(0) : acc_lnk[(i == 0) ? 0 : i - 1]),
			.own       (own_lnk[i]),
			.strm      (strm_lnk[i]),
			.acc       (acc_lnk[i])
		);
	end

	wemc_min u_min (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mctl),
		.tail_v   (own_lnk[MAX_TOWERS-1].v),
		.tail_acc (acc_lnk[MAX_TOWERS-1]),
		.best     (best)
	);

	assign done     = done_q;
	assign min_cost = min_cost_q;
	assign overflow = overflow_q;

endmodule

// ----- sim/weighted_equalize_min_cost_tb.sv -----
// weighted_equalize_min_cost_tb: self-checking bench for the weighted tower
// equalizer. Depends on wemc_pkg and weighted_equalize_min_cost only.
// Directed extremes first, then random tower sets scored by a local cost model.
`timescale 1ns / 100ps

module weighted_equalize_min_cost_tb;

	import wemc_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RANDOM_ITEMS = 630;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SHOW_MAX     = 10;
	localparam logic [63:0] COST_CEIL = (64'd1 << COST_W) - 64'd1;

	// one directed tower beat, with an optional hand-computed answer
	typedef struct packed {
		logic [H_W-1:0]    h;
		logic [C_W-1:0]    c;
		logic              l;
		logic              typed;
		logic [COST_W-1:0] cost;
		logic              ovf;
	} probe_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              ovf;
	} answer_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic [H_W-1:0]      height;
	logic [C_W-1:0]      unit_cost;
	logic                last;
	logic                done;
	logic [COST_W-1:0]   min_cost;
	logic                overflow;

	// hand-computed answer travelling with the beat that closes a set
	logic                typed_check;
	logic [COST_W-1:0]   typed_cost;
	logic                typed_ovf;

	// local copy of the tower store
	logic [H_W-1:0]      set_h [MAX_TOWERS];
	logic [C_W-1:0]      set_c [MAX_TOWERS];
	int                  set_n;
	logic                set_dropped;

	answer_t             answers_due [$];
	int                  fail_count;
	int                  cycle_count;

	probe_t directed_rows [19] = '{
		'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 40'd0,          1'b0},
		'{16'h0000, 16'h0000, 1'b1, 1'b1, 40'd0,          1'b0},
		'{16'h0000, 16'hFFFF, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 40'd4294836225, 1'b0},
		'{16'h0000, 16'h0000, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'hFFFF, 16'h0007, 1'b1, 1'b1, 40'd0,          1'b0},
		'{16'h1234, 16'h0001, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'h1234, 16'h00FF, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'h1234, 16'hFFFF, 1'b1, 1'b1, 40'd0,          1'b0},
		'{16'h0010, 16'h0003, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'h0020, 16'h0001, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'h0005, 16'h0002, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'h8000, 16'h0001, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'h0011, 16'h0004, 1'b1, 1'b0, 40'd0,          1'b0},
		'{16'hAAAA, 16'h5555, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'h5555, 16'hAAAA, 1'b1, 1'b0, 40'd0,          1'b0},
		'{16'h7FFF, 16'h8000, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'h8000, 16'h7FFF, 1'b0, 1'b0, 40'd0,          1'b0},
		'{16'h0001, 16'hFFFE, 1'b1, 1'b0, 40'd0,          1'b0}
	};

	weighted_equalize_min_cost uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.height    (height),
		.unit_cost (unit_cost),
		.last      (last),
		.done      (done),
		.min_cost  (min_cost),
		.overflow  (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		fail_count++;
		if (fail_count <= SHOW_MAX)
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
	endtask

	// store one tower; on a closing beat, score every stored height as the target
	task automatic absorb_tower(input logic [H_W-1:0] h, input logic [C_W-1:0] c,
			input logic l, output logic closes, output answer_t ans);
		logic [63:0] total;
		logic [63:0] best;
		logic [63:0] diff;
		logic [H_W-1:0] aim;
		int t;
		int i;
		closes = 1'b0;
		ans = '0;
		if (set_n < MAX_TOWERS) begin
			set_h[set_n] = h;
			set_c[set_n] = c;
			set_n++;
		end else begin
			set_dropped = 1'b1;
		end
		if (l) begin
			best = '0;
			for (t = 0; t < set_n; t++) begin
				aim = set_h[t];
				total = '0;
				for (i = 0; i < set_n; i++) begin
					diff = (set_h[i] > aim) ? 64'(set_h[i] - aim) : 64'(aim - set_h[i]);
					total += diff * 64'(set_c[i]);
				end
				if (t == 0 || total < best)
					best = total;
			end
			if (best > COST_CEIL)
				best = COST_CEIL;
			closes = 1'b1;
			ans.cost = best[COST_W-1:0];
			ans.ovf = set_dropped;
			set_n = 0;
			set_dropped = 1'b0;
		end
	endtask

	// accept tower beats and score answers at the rising edge
	always @(posedge clk) begin
		logic closes;
		answer_t ans;
		answer_t want;
		if (arst_n && start && !busy) begin
			absorb_tower(height, unit_cost, last, closes, ans);
			if (closes) begin
				if (typed_check) begin
					ans.cost = typed_cost;
					ans.ovf = typed_ovf;
				end
				answers_due.push_back(ans);
			end
		end
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				flag_mismatch("unrequested result, min_cost", 64'd0, 64'(min_cost));
			end else begin
				want = answers_due.pop_front();
				if (min_cost !== want.cost)
					flag_mismatch("min_cost", 64'(want.cost), 64'(min_cost));
				if (overflow !== want.ovf)
					flag_mismatch("overflow", 64'(want.ovf), 64'(overflow));
			end
		end
	end

	// present one beat and hold it until taken
	task automatic send_tower(input logic [H_W-1:0] h, input logic [C_W-1:0] c,
			input logic l, input logic typed, input logic [COST_W-1:0] cost,
			input logic ovf);
		@(negedge clk);
		start <= 1'b1;
		height <= h;
		unit_cost <= c;
		last <= l;
		typed_check <= typed;
		typed_cost <= cost;
		typed_ovf <= ovf;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// sender idle: mostly short, now and then long
	task automatic pause_towers();
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			gap = 0;
		else if (pick < 90)
			gap = $urandom_range(1, 3);
		else
			gap = $urandom_range(10, 40);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	initial begin
		int k;
		int j;
		int sent;
		int sets_done;
		int len;
		int hstyle;
		int cstyle;
		int pick;
		logic quiet;
		logic [H_W-1:0] base;
		logic [H_W-1:0] h;
		logic [C_W-1:0] c;

		start = 1'b0;
		height = '0;
		unit_cost = '0;
		last = 1'b0;
		typed_check = 1'b0;
		typed_cost = '0;
		typed_ovf = 1'b0;
		arst_n = 1'b0;
		set_n = 0;
		set_dropped = 1'b0;
		fail_count = 0;
		cycle_count = 0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed extremes and small sets, partly hand-checked
		for (k = 0; k < 19; k++) begin
			send_tower(directed_rows[k].h, directed_rows[k].c, directed_rows[k].l,
				directed_rows[k].typed, directed_rows[k].cost, directed_rows[k].ovf);
			pause_towers();
		end

		// random sets; the first three fill the store exactly and then past it
		sent = 0;
		sets_done = 0;
		while (sent < RANDOM_ITEMS) begin
			case (sets_done)
				0: len = MAX_TOWERS;
				1: len = MAX_TOWERS + 1;
				2: len = MAX_TOWERS + 6;
				default: begin
					pick = $urandom_range(0, 99);
					if (pick < 80)
						len = $urandom_range(1, 6);
					else if (pick < 95)
						len = $urandom_range(7, 20);
					else
						len = $urandom_range(MAX_TOWERS - 4, MAX_TOWERS + 6);
				end
			endcase
			quiet = ($urandom_range(0, 3) == 0);
			hstyle = $urandom_range(0, 2);
			cstyle = $urandom_range(0, 2);
			base = H_W'($urandom_range(0, 65535 - 15));
			for (j = 0; j < len; j++) begin
				case (hstyle)
					0: h = H_W'($urandom_range(0, 65535));
					1: h = base + H_W'($urandom_range(0, 15));
					default: h = H_W'($urandom_range(0, 3));
				endcase
				case (cstyle)
					0: c = C_W'($urandom_range(0, 65535));
					1: c = C_W'($urandom_range(0, 7));
					default: c = ($urandom_range(0, 2) == 0) ? '0 : C_W'($urandom_range(0, 65535));
				endcase
				send_tower(h, c, (j == len - 1), 1'b0, '0, 1'b0);
				if (!quiet)
					pause_towers();
			end
			sent += len;
			sets_done++;
		end

		@(negedge clk);
		start <= 1'b0;

		// drain outstanding answers, then watch for stray strobes
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (2 * MAX_TOWERS + 8) @(posedge clk);

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
